FILE: hw/rtl/ubx_frame_parser_unit_macros.svh
// Assertion macros for the UBX frame parser unit and its checker.
// Expect clk and rst_n in the scope where they are used.
`ifndef UBX_FRAME_PARSER_UNIT_MACROS_SVH
`define UBX_FRAME_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define UBXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define UBXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ubxp_pkg.sv
// Shared types and constants for the UBX frame parser unit.
// No dependencies; used by the core, the top level and the checker.
package ubxp_pkg;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_OVERSIZE = 2'd2;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h62;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [9:0]  position;
        logic [7:0]  frame_class;
        logic [7:0]  frame_ident;
        logic [15:0] frame_length;
        logic        checksum_ok;
    } result_t;

endpackage

FILE: hw/rtl/ubxp_core.sv
// Frame parser state machine: sync hunt, header capture, Fletcher-8 sum.
// Depends on ubxp_pkg; instantiated by ubx_frame_parser_unit.
module ubxp_core #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    output logic              res_valid,
    output ubxp_pkg::result_t res
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    ubxp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    class_reg, class_next;
    logic [7:0]    ident_reg, ident_next;
    logic [15:0]   length_reg, length_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    sum_a_reg, sum_a_next;
    logic [7:0]    sum_b_reg, sum_b_next;
    logic [7:0]    rcv_a_reg, rcv_a_next;

    logic [7:0]    add_a;
    logic [7:0]    add_b;
    logic [15:0]   len_full;
    logic [CW-1:0] cnt_inc;
    logic [15:0]   pos16;

    assign add_a    = sum_a_reg + rx_byte;
    assign add_b    = sum_b_reg + add_a;
    assign len_full = {rx_byte, length_reg[7:0]};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign pos16    = 16'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ubxp_pkg::PH_SYNC1;
            class_reg  <= '0;
            ident_reg  <= '0;
            length_reg <= '0;
            cnt_reg    <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            rcv_a_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            ident_reg  <= ident_next;
            length_reg <= length_next;
            cnt_reg    <= cnt_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            rcv_a_reg  <= rcv_a_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        ident_next  = ident_reg;
        length_next = length_reg;
        cnt_next    = cnt_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        rcv_a_next  = rcv_a_reg;

        res_valid        = 1'b0;
        res.kind         = ubxp_pkg::KIND_PAYLOAD;
        res.value        = '0;
        res.position     = '0;
        res.frame_class  = class_reg;
        res.frame_ident  = ident_reg;
        res.frame_length = length_reg;
        res.checksum_ok  = 1'b0;

        case (phase_reg)
            ubxp_pkg::PH_SYNC1:
            begin
                if (rx_byte == sync_first)
                    phase_next = ubxp_pkg::PH_SYNC2;
            end
            ubxp_pkg::PH_SYNC2:
            begin
                // second-sync match wins when both registers hold the same value
                if (rx_byte == sync_second)
                begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                    phase_next = ubxp_pkg::PH_CLASS;
                end
                else if (rx_byte != sync_first)
                    phase_next = ubxp_pkg::PH_SYNC1;
            end
            ubxp_pkg::PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = ubxp_pkg::PH_IDENT;
            end
            ubxp_pkg::PH_IDENT:
            begin
                ident_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = ubxp_pkg::PH_LEN_LO;
            end
            ubxp_pkg::PH_LEN_LO:
            begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = ubxp_pkg::PH_LEN_HI;
            end
            ubxp_pkg::PH_LEN_HI:
            begin
                length_next = len_full;
                cnt_next    = '0;
                if (17'(len_full) > 17'(MAX_PAYLOAD))
                begin
                    res_valid        = 1'b1;
                    res.kind         = ubxp_pkg::KIND_OVERSIZE;
                    res.frame_length = len_full;
                    sum_a_next       = '0;
                    sum_b_next       = '0;
                    phase_next       = ubxp_pkg::PH_SYNC1;
                end
                else
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    phase_next = (len_full == 16'd0) ? ubxp_pkg::PH_CK_A
                                                     : ubxp_pkg::PH_PAYLOAD;
                end
            end
            ubxp_pkg::PH_PAYLOAD:
            begin
                sum_a_next   = add_a;
                sum_b_next   = add_b;
                res_valid    = 1'b1;
                res.kind     = ubxp_pkg::KIND_PAYLOAD;
                res.value    = rx_byte;
                res.position = pos16[9:0];
                cnt_next     = cnt_inc;
                if (17'(cnt_inc) >= 17'(length_reg))
                    phase_next = ubxp_pkg::PH_CK_A;
            end
            ubxp_pkg::PH_CK_A:
            begin
                rcv_a_next = rx_byte;
                phase_next = ubxp_pkg::PH_CK_B;
            end
            ubxp_pkg::PH_CK_B:
            begin
                res_valid       = 1'b1;
                res.kind        = ubxp_pkg::KIND_COMPLETE;
                res.checksum_ok = (rcv_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
                cnt_next        = '0;
                sum_a_next      = '0;
                sum_b_next      = '0;
                phase_next      = ubxp_pkg::PH_SYNC1;
            end
            default:
            begin
                cnt_next   = '0;
                sum_a_next = '0;
                sum_b_next = '0;
                phase_next = ubxp_pkg::PH_SYNC1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ubx_frame_parser_unit.sv
// Top level of the UBX frame parser: config registers, core, output skid pair.
// Depends on ubxp_pkg and ubxp_core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | rx_byte
//  output   | out_valid / out_stall| result_kind, payload_value, payload_position,
//           |                      | frame_class, frame_ident, frame_length,
//           |                      | checksum_ok
//  config   | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low, set by the state update in ubxp_core
// (8-bit adds): each transaction is parsed in the cycle it is accepted, and its
// result (if any) enters the output register, or the skid register on a stall.
// Reset (rst_n low, asynchronous) returns the parser to the sync hunt and restores
// the standard sync bytes 0xB5 / 0x62.
// A stalled output keeps its transaction; one more result goes to the skid
// register, and in_stall rises only once that skid register is full.
module ubx_frame_parser_unit #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_value,
    output logic [9:0]  payload_position,
    output logic [7:0]  frame_class,
    output logic [7:0]  frame_ident,
    output logic [15:0] frame_length,
    output logic        checksum_ok,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    logic              in_take;
    logic              core_valid;
    ubxp_pkg::result_t core_res;

    logic              out_valid_reg, out_valid_next;
    ubxp_pkg::result_t out_reg, out_next;
    logic              skid_valid_reg, skid_valid_next;
    ubxp_pkg::result_t skid_reg, skid_next;
    logic              out_free;
    logic              new_res;

    // Sync byte registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= ubxp_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= ubxp_pkg::SYNC_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ubxp_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                ubxp_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Stall only when the skid slot is occupied: that is the sole case in which
    // a result from the next byte would have nowhere to go.
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;

    ubxp_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_take),
        .rx_byte     (rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res_valid   (core_valid),
        .res         (core_res)
    );

    assign new_res  = in_take && core_valid;
    // output register empties this cycle or is already empty
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // older result first; a new one cannot arrive while skid is full
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = new_res;
                out_next       = core_res;
            end
        end
        else if (new_res)
        begin
            skid_valid_next = 1'b1;
            skid_next       = core_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_reg.kind;
    assign payload_value    = out_reg.value;
    assign payload_position = out_reg.position;
    assign frame_class      = out_reg.frame_class;
    assign frame_ident      = out_reg.frame_ident;
    assign frame_length     = out_reg.frame_length;
    assign checksum_ok      = out_reg.checksum_ok;

endmodule

FILE: hw/rtl/ubxp_checker.sv
// Port-level checker for ubx_frame_parser_unit, attached by bind below.
// Depends on ubxp_pkg and ubx_frame_parser_unit_macros.svh.
`include "ubx_frame_parser_unit_macros.svh"

module ubxp_checker #(
    parameter int MAX_PAYLOAD = 1024
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [7:0]  payload_value,
    input logic [9:0]  payload_position,
    input logic [7:0]  frame_class,
    input logic [7:0]  frame_ident,
    input logic [15:0] frame_length,
    input logic        checksum_ok
);

    logic        out_held;
    logic [52:0] out_word;
    logic        oversize_out;
    logic        len_over;
    logic        other_out;
    logic        side_clean;

    assign out_held     = out_valid && out_stall;
    assign out_word     = {result_kind, payload_value, payload_position, frame_class,
                           frame_ident, frame_length, checksum_ok};
    assign oversize_out = out_valid && (result_kind == ubxp_pkg::KIND_OVERSIZE);
    assign len_over     = 17'(frame_length) > 17'(MAX_PAYLOAD);
    assign other_out    = out_valid && (result_kind != ubxp_pkg::KIND_PAYLOAD);
    assign side_clean   = (payload_value == 8'd0) && (payload_position == 10'd0)
                          && ((result_kind == ubxp_pkg::KIND_COMPLETE) || !checksum_ok);

    `UBXP_ASSERT_NEXT(a_out_hold, out_held, out_valid, "out_valid dropped under stall")

    `UBXP_ASSERT_NEXT(a_out_stable, out_held, $stable(out_word), "stalled result changed")

    `UBXP_ASSERT_NOW(a_oversize_len, oversize_out, len_over, "oversize result, legal length")

    `UBXP_ASSERT_NOW(a_non_payload_zero, other_out, side_clean, "stray payload or checksum")

    `UBXP_ASSERT_NOW(a_stall_out, in_stall, out_valid, "input stalled, no result waiting")

endmodule

bind ubx_frame_parser_unit ubxp_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_ubxp_checker (.*);

FILE: tb/tb_ubx_frame_parser_unit.sv
// Self-checking testbench for ubx_frame_parser_unit: byte stream in, parse events out.
// Needs ubxp_pkg and the parser RTL; stands alone otherwise (no files, no plusargs).
// Directed table first, then randomised frames under several sync byte settings.
`timescale 1ns / 1ps

module tb_ubx_frame_parser_unit;

    localparam int MAX_LEN     = 1024;
    localparam int DRAIN       = 4;
    localparam int PHASE_BYTES = 70;         // random bytes per sync setting
    localparam int N_PHASES    = 6;
    localparam int LIMIT_NS    = 4_000_000;  // timeout, well over the slowest run

    // index with no register behind it; writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef enum bit {ROW_BYTE, ROW_SYNC} row_op_t;

    // One row of the directed table. ROW_SYNC rows rewrite both sync registers
    // (a, b) once the parser has gone quiet; ROW_BYTE rows send byte a. Where
    // the outcome is obvious, the expected transaction is typed into res.
    typedef struct {
        row_op_t           op;
        logic [7:0]        a;
        logic [7:0]        b;
        bit                typed;
        ubxp_pkg::result_t res;
    } row_t;

    localparam ubxp_pkg::result_t NO_RES = '0;

    localparam int N_ROWS = 29;

    row_t script [N_ROWS] = '{
        // hunt: sync then junk drops back, then a doubled first sync byte
        '{ROW_BYTE, 8'hB5, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hB5, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hB5, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h62, 8'h00, 1'b0, NO_RES},
        // class 01, id 07, length 1025: one over the payload limit
        '{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h07, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h04, 8'h00, 1'b1,
          '{ubxp_pkg::KIND_OVERSIZE, 8'h00, 10'd0, 8'h01, 8'h07, 16'd1025, 1'b0}},
        // all-ones class and id, empty payload, good checksum FE F9
        '{ROW_BYTE, 8'hB5, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h62, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hFF, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hFF, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hFE, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hF9, 8'h00, 1'b1,
          '{ubxp_pkg::KIND_COMPLETE, 8'h00, 10'd0, 8'hFF, 8'hFF, 16'd0, 1'b1}},
        // all-zero class and id, one payload byte FF, bad second checksum byte
        '{ROW_BYTE, 8'hB5, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h62, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'hFF, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b1,
          '{ubxp_pkg::KIND_COMPLETE, 8'h00, 10'd0, 8'h00, 8'h00, 16'd1, 1'b0}},
        // both sync registers zero: a byte matching both is the second sync
        '{ROW_SYNC, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES},
        '{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_RES}
    };

    // DUT inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = ubxp_pkg::REG_SYNC_FIRST;
    logic [7:0]  cfg_data  = 8'h00;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  result_kind;
    logic [7:0]  payload_value;
    logic [9:0]  payload_position;
    logic [7:0]  frame_class;
    logic [7:0]  frame_ident;
    logic [15:0] frame_length;
    logic        checksum_ok;

    // parser mirror: sync registers and frame state
    logic [7:0]       sync_a_cfg = ubxp_pkg::SYNC_FIRST_RESET;
    logic [7:0]       sync_b_cfg = ubxp_pkg::SYNC_SECOND_RESET;
    ubxp_pkg::phase_t cur_phase  = ubxp_pkg::PH_SYNC1;
    logic [7:0]       cur_class  = '0;
    logic [7:0]       cur_ident  = '0;
    logic [15:0]      cur_len    = '0;
    logic [10:0]      pay_count  = '0;
    logic [7:0]       fl_a       = '0;
    logic [7:0]       fl_b       = '0;
    logic [7:0]       rx_ck_a    = '0;

    ubxp_pkg::result_t parsed_q [$];   // parse events still owed by the DUT
    int      errors     = 0;
    int      sent       = 0;
    bit      sender_calm = 1'b0;
    int      stall_left = 0;
    int      calm_left  = 0;

    ubx_frame_parser_unit #(
        .MAX_PAYLOAD (MAX_LEN)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .payload_value    (payload_value),
        .payload_position (payload_position),
        .frame_class      (frame_class),
        .frame_ident      (frame_ident),
        .frame_length     (frame_length),
        .checksum_ok      (checksum_ok),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL ubx_frame_parser_unit");
        $finish;
    end

    // Idle length in cycles: mostly none or short, now and then a long one.
    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void fletcher_add(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    function automatic void resync();
        cur_phase = ubxp_pkg::PH_SYNC1;
        pay_count = '0;
        fl_a      = '0;
        fl_b      = '0;
    endfunction

    // Advance the mirror by one byte; returns 1 when the byte yields a transaction.
    function automatic bit parse_byte(input logic [7:0] b, output ubxp_pkg::result_t r);
        bit has;
        has = 1'b0;
        r   = '0;
        case (cur_phase)
            ubxp_pkg::PH_SYNC1:
                if (b == sync_a_cfg)
                    cur_phase = ubxp_pkg::PH_SYNC2;
            ubxp_pkg::PH_SYNC2:
                // second sync is compared first, so equal registers still lock on
                if (b == sync_b_cfg)
                begin
                    fl_a      = '0;
                    fl_b      = '0;
                    cur_phase = ubxp_pkg::PH_CLASS;
                end
                else if (b != sync_a_cfg)
                    cur_phase = ubxp_pkg::PH_SYNC1;
            ubxp_pkg::PH_CLASS:
            begin
                cur_class = b;
                fletcher_add(b);
                cur_phase = ubxp_pkg::PH_IDENT;
            end
            ubxp_pkg::PH_IDENT:
            begin
                cur_ident = b;
                fletcher_add(b);
                cur_phase = ubxp_pkg::PH_LEN_LO;
            end
            ubxp_pkg::PH_LEN_LO:
            begin
                cur_len = {8'h00, b};
                fletcher_add(b);
                cur_phase = ubxp_pkg::PH_LEN_HI;
            end
            ubxp_pkg::PH_LEN_HI:
            begin
                cur_len[15:8] = b;
                fletcher_add(b);
                pay_count = '0;
                if (cur_len > MAX_LEN)
                begin
                    has = 1'b1;
                    r   = '{ubxp_pkg::KIND_OVERSIZE, 8'h00, 10'd0,
                            cur_class, cur_ident, cur_len, 1'b0};
                    resync();
                end
                else
                    cur_phase = (cur_len == 16'd0) ? ubxp_pkg::PH_CK_A
                                                   : ubxp_pkg::PH_PAYLOAD;
            end
            ubxp_pkg::PH_PAYLOAD:
            begin
                fletcher_add(b);
                has = 1'b1;
                r   = '{ubxp_pkg::KIND_PAYLOAD, b, pay_count[9:0],
                        cur_class, cur_ident, cur_len, 1'b0};
                pay_count = pay_count + 11'd1;
                if ({5'd0, pay_count} >= cur_len)
                    cur_phase = ubxp_pkg::PH_CK_A;
            end
            ubxp_pkg::PH_CK_A:
            begin
                rx_ck_a   = b;
                cur_phase = ubxp_pkg::PH_CK_B;
            end
            ubxp_pkg::PH_CK_B:
            begin
                has = 1'b1;
                r   = '{ubxp_pkg::KIND_COMPLETE, 8'h00, 10'd0, cur_class, cur_ident, cur_len,
                        (rx_ck_a == fl_a) && (b == fl_b)};
                resync();
            end
            default:
                resync();
        endcase
        return has;
    endfunction

    // One input transaction: optional idle, then hold valid until the DUT takes it.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input ubxp_pkg::result_t want = '0);
        ubxp_pkg::result_t r;
        bit                has;
        int                gap;
        gap = gap_len(sender_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        has = parse_byte(b, r);
        if (typed)
            parsed_q.push_back(want);
        else if (has)
            parsed_q.push_back(r);
    endtask

    // Drop valid, let every owed transaction come out, then wait out the DRAIN
    // margin for a byte that only moved the parser state.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Back-to-back writes: an unmapped index first, then both sync registers.
    task automatic apply_settings(input logic [7:0] first, input logic [7:0] second);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_index <= ubxp_pkg::REG_SYNC_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        sync_a_cfg = first;
        cfg_index <= ubxp_pkg::REG_SYNC_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        sync_b_cfg = second;
        cfg_we    <= 1'b0;
    endtask

    // Build a frame under the current sync bytes and send it, or only a prefix
    // of it when cut is set. Oversize lengths end right after the length field.
    task automatic send_frame(input logic [15:0] len, input bit good_sum, input bit cut);
        logic [7:0] q [$];
        logic [7:0] body [$];
        logic [7:0] sa;
        logic [7:0] sb;
        int         stop;
        sa = '0;
        sb = '0;
        q.push_back(sync_a_cfg);
        if ($urandom_range(0, 5) == 0)
            q.push_back(sync_a_cfg);
        q.push_back(sync_b_cfg);
        body = {8'($urandom), 8'($urandom), len[7:0], len[15:8]};
        if (len <= MAX_LEN)
            repeat (len) body.push_back(8'($urandom));
        foreach (body[k])
        begin
            sa = sa + body[k];
            sb = sb + sa;
            q.push_back(body[k]);
        end
        if (len <= MAX_LEN)
        begin
            if (!good_sum)
            begin
                if ($urandom_range(0, 1) == 1)
                    sa ^= 8'($urandom_range(1, 255));
                else
                    sb ^= 8'($urandom_range(1, 255));
            end
            q.push_back(sa);
            q.push_back(sb);
        end
        stop = cut ? $urandom_range(1, q.size() - 1) : q.size();
        for (int k = 0; k < stop; k++)
            send_byte(q[k]);
    endtask

    // Mostly well-formed frames with short payloads; some noise, oversize
    // lengths, bad checksums and truncated frames mixed in.
    task automatic random_frame();
        int          r;
        logic [15:0] len;
        sender_calm = ($urandom_range(0, 6) == 0);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        if ($urandom_range(0, 4) == 0)
            send_byte(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 60)
            len = 16'($urandom_range(0, 6));
        else if (r < 82)
            len = 16'($urandom_range(7, 64));
        else if (r < 88)
            len = 16'(MAX_LEN + 1);
        else if (r < 92)
            len = 16'hFFFF;
        else if (r < 96)
            len = 16'($urandom_range(65535, MAX_LEN + 2));
        else
            len = 16'd0;
        send_frame(len, $urandom_range(0, 9) != 0, $urandom_range(0, 11) == 0);
    endtask

    // Receiver: random stalls, with occasional calm stretches of none at all.
    always @(posedge clk)
    begin
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 299) == 0)
            calm_left = $urandom_range(40, 160);
        if (stall_left > 0)
            stall_left--;
        else
            stall_left = gap_len(calm_left > 0);
        out_stall <= (stall_left > 0);
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Every accepted output transaction is matched against the oldest owed one.
    always @(posedge clk)
    begin
        ubxp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (parsed_q.size() == 0)
            begin
                $error("unexpected transaction: result_kind %0d", result_kind);
                errors++;
            end
            else
            begin
                want = parsed_q.pop_front();
                check_field("result_kind", 16'(want.kind), 16'(result_kind));
                check_field("payload_value", 16'(want.value), 16'(payload_value));
                check_field("payload_position", 16'(want.position),
                            16'(payload_position));
                check_field("frame_class", 16'(want.frame_class), 16'(frame_class));
                check_field("frame_ident", 16'(want.frame_ident), 16'(frame_ident));
                check_field("frame_length", want.frame_length, frame_length);
                check_field("checksum_ok", 16'(want.checksum_ok), 16'(checksum_ok));
            end
        end
    end

    initial
    begin
        logic [7:0] first;
        logic [7:0] second;
        int         start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, run under the reset sync bytes until a sync row
        foreach (script[i])
        begin
            if (script[i].op == ROW_SYNC)
            begin
                wait_idle();
                apply_settings(script[i].a, script[i].b);
            end
            else
                send_byte(script[i].a, script[i].typed, script[i].res);
        end

        // random frames under standard, extreme, equal and random sync bytes
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    first  = ubxp_pkg::SYNC_FIRST_RESET;
                    second = ubxp_pkg::SYNC_SECOND_RESET;
                end
                1:
                begin
                    first  = 8'h00;
                    second = 8'hFF;
                end
                2:
                begin
                    first  = 8'hFF;
                    second = 8'h00;
                end
                3:
                begin
                    first  = 8'hAA;
                    second = 8'hAA;
                end
                default:
                begin
                    first  = 8'($urandom);
                    second = 8'($urandom);
                end
            endcase
            wait_idle();
            apply_settings(first, second);
            start = sent;
            while (sent - start < PHASE_BYTES)
                random_frame();
        end

        wait_idle();
        if (errors == 0)
            $display("PASS ubx_frame_parser_unit");
        else
            $display("FAIL ubx_frame_parser_unit");
        $finish;
    end

endmodule
